@@ src/ffsa_pkg.sv @@
// Package for the first-fit segment allocator: sizes, operation and status codes.
// No dependencies.
`default_nettype none
package ffsa_pkg;
  localparam int MaxSegments = 64;
  localparam int AddrWidth   = 32;
  localparam int IdWidth     = 16;
  localparam int IdxWidth    = $clog2(MaxSegments);
  localparam int CntWidth    = $clog2(MaxSegments + 1);

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_INIT    = 2'd2;
  localparam logic [1:0] FUNC_NONE    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NO_ID    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [31:0] CapReset = 32'd1048576;

  typedef struct packed {
    logic                 is_block;
    logic [IdWidth-1:0]   owner;
    logic [AddrWidth-1:0] size;
    logic [AddrWidth-1:0] start;
  } seg_t;
endpackage
`default_nettype wire

@@ src/first_fit_segment_allocator.sv @@
// Top level of the first-fit segment allocator: segment table memory, scan and
// shift sequencer, output register. Depends on ffsa_pkg.
//
// Usage: write memory_capacity through cfg_we/cfg_wdata while idle; it takes
// effect at the next initialize. Send one word per request on s_axis
// (func, req_size, target_id); one result word comes back on m_axis
// (status, block_id, start_address).
// Flow: the block takes one word at a time. The segment table is one memory
// with one registered read port, walked by a small sequencer. A scan reads each
// entry into the read register and then compares it. An allocate stops at the
// first hole that fits; a split moves the entries above it up one place, top
// entry first, then writes the block and the tail hole. No fit ends the scan
// at the last entry. A release scans the whole table, keeping the last match,
// reads the right and then the left neighbor, writes the merged hole and moves
// the tail down. Initialize writes one hole of the capacity at address 0.
// Reset: rst loads the reset capacity, writes one hole of 1048576 bytes at
// address 0 and restarts ids at 1; no clearing pass is needed since only
// entries below seg_count are ever used.
// Stall: the result stays in the output register until m_axis_tready; a new
// word is taken only once the previous result has been taken.
`default_nettype none
module first_fit_segment_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] func, [33:2] req_size, [49:34] target_id, [55:50] zero
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] status, [17:2] block_id, [49:18] start_address, [55:50] zero
  output logic [55:0]      m_axis_tdata
);
  import ffsa_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RST     = 4'd1;  // write the reset hole, no result
  localparam logic [3:0] S_INIT    = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;  // read issued, compare next cycle
  localparam logic [3:0] S_CMP     = 4'd4;
  localparam logic [3:0] S_MV_RD   = 4'd5;  // move: read source entry
  localparam logic [3:0] S_MV_WR   = 4'd6;  // move: write it one or two places on
  localparam logic [3:0] S_WR_BLK  = 4'd7;
  localparam logic [3:0] S_WR_TAIL = 4'd8;
  localparam logic [3:0] S_NB_R    = 4'd9;  // release: read right neighbor
  localparam logic [3:0] S_NB_L    = 4'd10; // latch right, read left neighbor
  localparam logic [3:0] S_NB_CMP  = 4'd11;
  localparam logic [3:0] S_WR_MRG  = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  // Segment table.
  seg_t                  mem [MaxSegments];
  seg_t                  rd;
  logic [IdxWidth-1:0]   raddr;
  logic                  we;
  logic [IdxWidth-1:0]   waddr;
  seg_t                  wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wd;
    end
    rd <= mem[raddr];
  end

  logic [3:0]            state;
  logic [31:0]           capacity;
  logic [CntWidth-1:0]   seg_count;
  logic [IdWidth-1:0]    next_id;
  logic [1:0]            func;
  logic [AddrWidth-1:0]  req;
  logic [IdWidth-1:0]    target;
  logic [CntWidth-1:0]   idx;      // scan pointer
  logic                  found;
  logic                  split;
  logic [IdxWidth-1:0]   hit;
  seg_t                  hit_seg;  // entry being allocated or released
  seg_t                  nb;       // saved right neighbor
  logic                  merge_r;
  logic [IdxWidth-1:0]   mrg_at;   // where the merged hole lands
  logic [CntWidth-1:0]   mv_src;
  logic [CntWidth-1:0]   mv_last;
  logic [1:0]            mv_dist;  // entries removed by a release
  logic [1:0]            status;
  logic [IdWidth-1:0]    res_id;
  logic [AddrWidth-1:0]  res_addr;

  logic s_fire;
  logic m_fire;
  logic hole_fits;
  logic hit_now;
  logic left_free;
  logic [CntWidth-1:0]  hit_ext;
  logic [CntWidth-1:0]  mv_dst;
  logic [AddrWidth-1:0] mrg_size;

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign hole_fits     = !rd.is_block && (rd.size >= req);
  assign hit_now       = rd.is_block && (rd.owner == target);
  assign left_free     = (hit != '0) && !rd.is_block;
  assign hit_ext       = CntWidth'(hit);
  // Allocate moves the tail up one entry, release moves it down.
  assign mv_dst        = (func == FUNC_ALLOC) ? mv_src + CntWidth'(1)
                                              : mv_src - CntWidth'(mv_dist);
  assign mrg_size      = hit_seg.size + (left_free ? rd.size : '0)
                         + (merge_r ? nb.size : '0);
  assign m_axis_tdata  = {6'd0, res_addr, res_id, status};

  always_comb begin
    raddr = idx[IdxWidth-1:0];
    we    = 1'b0;
    waddr = hit;
    wd    = hit_seg;
    unique case (state)
      S_MV_RD: raddr = mv_src[IdxWidth-1:0];
      S_NB_R:  raddr = hit + IdxWidth'(1);
      S_NB_L:  raddr = hit - IdxWidth'(1);
      S_MV_WR: begin
        we    = 1'b1;
        waddr = mv_dst[IdxWidth-1:0];
        wd    = rd;
      end
      S_WR_BLK: begin
        we = 1'b1;
        wd = '{is_block: 1'b1, owner: next_id, size: req, start: hit_seg.start};
      end
      S_WR_TAIL: begin
        we    = 1'b1;
        waddr = hit + IdxWidth'(1);
        wd    = '{is_block: 1'b0, owner: '0, size: hit_seg.size - req,
                  start: hit_seg.start + req};
      end
      S_WR_MRG: begin
        we    = 1'b1;
        waddr = mrg_at;
      end
      S_INIT, S_RST: begin
        we    = 1'b1;
        waddr = '0;
        wd    = '{is_block: 1'b0, owner: '0, size: capacity, start: '0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_RST;
      capacity      <= CapReset;
      seg_count     <= CntWidth'(1);
      next_id       <= IdWidth'(1);
      m_axis_tvalid <= 1'b0;
      func          <= FUNC_INIT;
      status        <= ST_OK;
      res_id        <= '0;
      res_addr      <= '0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (m_fire) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            func     <= s_axis_tdata[1:0];
            req      <= s_axis_tdata[33:2];
            target   <= s_axis_tdata[49:34];
            idx      <= '0;
            found    <= 1'b0;
            split    <= 1'b0;
            status   <= ST_OK;
            res_id   <= '0;
            res_addr <= '0;
            unique case (s_axis_tdata[1:0])
              FUNC_ALLOC: begin
                if (s_axis_tdata[33:2] == '0) begin
                  status <= ST_NO_SPACE;
                  state  <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              FUNC_RELEASE: state <= S_SCAN;
              FUNC_INIT:    state <= S_INIT;
              default:      state <= S_DONE;
            endcase
          end
        end
        S_RST: begin
          state <= S_IDLE;
        end
        S_INIT: begin
          seg_count <= CntWidth'(1);
          state     <= S_DONE;
        end
        S_SCAN: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (func == FUNC_ALLOC) begin
            if (hole_fits) begin
              hit     <= idx[IdxWidth-1:0];
              hit_seg <= rd;
              if (rd.size == req) begin
                state <= S_WR_BLK;
              end else if (seg_count == CntWidth'(MaxSegments)) begin
                status <= ST_FULL;
                state  <= S_DONE;
              end else begin
                split <= 1'b1;
                if (idx + CntWidth'(1) == seg_count) begin
                  state <= S_WR_BLK;
                end else begin
                  // open a gap at hit+1, moving the top entry first
                  mv_src  <= seg_count - CntWidth'(1);
                  mv_last <= idx + CntWidth'(1);
                  state   <= S_MV_RD;
                end
              end
            end else if (idx + CntWidth'(1) == seg_count) begin
              status <= ST_NO_SPACE;
              state  <= S_DONE;
            end else begin
              idx   <= idx + CntWidth'(1);
              state <= S_SCAN;
            end
          end else begin
            // release: keep the last match
            if (hit_now) begin
              found   <= 1'b1;
              hit     <= idx[IdxWidth-1:0];
              hit_seg <= rd;
            end
            if (idx + CntWidth'(1) == seg_count) begin
              if (hit_now || found) begin
                state <= S_NB_R;
              end else begin
                status <= ST_NO_ID;
                state  <= S_DONE;
              end
            end else begin
              idx   <= idx + CntWidth'(1);
              state <= S_SCAN;
            end
          end
        end
        S_MV_RD: begin
          state <= S_MV_WR;
        end
        S_MV_WR: begin
          if (mv_src == mv_last) begin
            state <= (func == FUNC_ALLOC) ? S_WR_BLK : S_DONE;
          end else begin
            mv_src <= (func == FUNC_ALLOC) ? mv_src - CntWidth'(1)
                                           : mv_src + CntWidth'(1);
            state  <= S_MV_RD;
          end
        end
        S_WR_BLK: begin
          res_id   <= next_id;
          res_addr <= hit_seg.start;
          next_id  <= (next_id + IdWidth'(1) == '0) ? IdWidth'(1)
                                                    : next_id + IdWidth'(1);
          if (split) begin
            seg_count <= seg_count + CntWidth'(1);
            state     <= S_WR_TAIL;
          end else begin
            state <= S_DONE;
          end
        end
        S_WR_TAIL: begin
          state <= S_DONE;
        end
        S_NB_R: begin
          state <= S_NB_L;
        end
        S_NB_L: begin
          // rd holds entry hit+1
          merge_r <= (hit_ext + CntWidth'(1) < seg_count) && !rd.is_block;
          nb      <= rd;
          state   <= S_NB_CMP;
        end
        S_NB_CMP: begin
          // rd holds entry hit-1; fold both free neighbors into one hole
          hit_seg.is_block <= 1'b0;
          hit_seg.owner    <= '0;
          hit_seg.size     <= mrg_size;
          if (left_free) begin
            hit_seg.start <= rd.start;
          end
          mrg_at  <= left_free ? hit - IdxWidth'(1) : hit;
          mv_dist <= {1'b0, left_free} + {1'b0, merge_r};
          mv_src  <= hit_ext + CntWidth'(1) + CntWidth'(merge_r);
          mv_last <= seg_count - CntWidth'(1);
          state   <= S_WR_MRG;
        end
        S_WR_MRG: begin
          seg_count <= seg_count - CntWidth'(mv_dist);
          state     <= ((mv_dist != 2'd0) && (mv_src < seg_count)) ? S_MV_RD : S_DONE;
        end
        S_DONE: begin
          m_axis_tvalid <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_busy_not_ready;
    @(posedge clk) disable iff (rst) (state != S_IDLE) |-> !s_axis_tready;
  endproperty
  a_busy_not_ready: assert property (p_busy_not_ready) else $error("ready while busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (seg_count >= CntWidth'(1)) && (seg_count <= CntWidth'(MaxSegments)))
    else $error("segment count out of range");

  a_id_nonzero: assert property (@(posedge clk) disable iff (rst) next_id != '0)
    else $error("id counter hit zero");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
endmodule
`default_nettype wire
